[src/terminal_escape_stripper_macros.svh]
// ----------------------------------------------------------------------------
// Terminal escape stripper assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n low as disable.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_ESCAPE_STRIPPER_MACROS_SVH
`define TERMINAL_ESCAPE_STRIPPER_MACROS_SVH

// Same-cycle implication.
`define TES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal_escape_stripper: same-cycle check failed");

// Next-cycle implication.
`define TES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal_escape_stripper: next-cycle check failed");

`endif

[src/tes_pkg.sv]
// ----------------------------------------------------------------------------
// Terminal escape stripper package
// Parser mode encoding, character codes and the printable-unit test.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int UNIT_W = 16;

    typedef logic [UNIT_W-1:0] unit_t;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } mode_t;

    localparam unit_t U_BEL      = 16'h0007;
    localparam unit_t U_TAB      = 16'h0009;
    localparam unit_t U_ESC      = 16'h001B;
    localparam unit_t U_SPACE    = 16'h0020;
    localparam unit_t U_CSI_LO   = 16'h0040;
    localparam unit_t U_LBRK     = 16'h005B;
    localparam unit_t U_BSL      = 16'h005C;
    localparam unit_t U_RBRK     = 16'h005D;
    localparam unit_t U_CSI_HI   = 16'h007E;
    localparam unit_t U_DEL      = 16'h007F;
    localparam unit_t U_C1_LO    = 16'h0080;
    localparam unit_t U_C1_END   = 16'h00A0;

    // True for units that pass as visible text outside a sequence.
    function automatic logic is_printable(input unit_t c);
        logic ok;
        begin
            ok = 1'b1;
            if (c < U_SPACE && c != U_TAB)
            begin
                ok = 1'b0;
            end
            if (c == U_DEL)
            begin
                ok = 1'b0;
            end
            if (c >= U_C1_LO && c < U_C1_END)
            begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

endpackage

[src/tes_parser.sv]
// ----------------------------------------------------------------------------
// Terminal escape stripper parser
// Escape-sequence state machine; decides whether the current unit is kept.
// ----------------------------------------------------------------------------
module tes_parser
    import tes_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  unit_t code_unit,
    input  logic  line_end,
    output logic  keep,
    output mode_t mode
);

    mode_t mode_reg;
    mode_t mode_next;
    mode_t mode_step;

    // Next state
    always_comb
    begin
        mode_step = MODE_NORMAL;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (code_unit == U_LBRK)
                    mode_step = MODE_CSI;
                else if (code_unit == U_RBRK)
                    mode_step = MODE_OSC;
                else
                    mode_step = MODE_NORMAL;
            end
            MODE_CSI:
            begin
                if (code_unit >= U_CSI_LO && code_unit <= U_CSI_HI)
                    mode_step = MODE_NORMAL;
                else
                    mode_step = MODE_CSI;
            end
            MODE_OSC:
            begin
                if (code_unit == U_BEL)
                    mode_step = MODE_NORMAL;
                else if (code_unit == U_ESC)
                    mode_step = MODE_OSC_ESC;
                else
                    mode_step = MODE_OSC;
            end
            MODE_OSC_ESC:
            begin
                if (code_unit == U_BSL || code_unit == U_BEL)
                    mode_step = MODE_NORMAL;
                else if (code_unit == U_ESC)
                    mode_step = MODE_OSC_ESC;
                else
                    mode_step = MODE_OSC;
            end
            default:
            begin
                if (code_unit == U_ESC)
                    mode_step = MODE_ESC;
                else
                    mode_step = MODE_NORMAL;
            end
        endcase
        // line end always returns to normal text
        mode_next = mode_reg;
        if (advance)
            mode_next = line_end ? MODE_NORMAL : mode_step;
    end

    // Outputs
    always_comb
    begin
        keep = 1'b0;
        unique case (mode_reg)
            MODE_ESC, MODE_CSI, MODE_OSC, MODE_OSC_ESC:
                keep = 1'b0;
            default:
                keep = (code_unit != U_ESC) && is_printable(code_unit);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NORMAL;
        else
            mode_reg <= mode_next;
    end

    assign mode = mode_reg;

endmodule

[src/terminal_escape_stripper.sv]
// ----------------------------------------------------------------------------
// Terminal escape stripper
// Drops CSI, OSC and two-unit escape sequences plus control codes from a
// stream of 16-bit text code units; passes printable text unchanged.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | code_unit, line_end
//  out     | out of    | out_valid/out_stall| keep, out_unit, out_line_end
//
//  One transaction per cycle sustained while out does not stall; a unit's
//  result passes through the input register, then the result register,
//  before it is presented on out.
//  The parser mode register advances once per unit moved into the result
//  register, so mode update and classification share one short path.
//  Reset clears both stage valid flags and returns the parser to normal text.
//  A stall on out holds the result register; in stalls only when both
//  registers are full and the result is not taken in that cycle.
// ----------------------------------------------------------------------------
`include "terminal_escape_stripper_macros.svh"

module terminal_escape_stripper
    import tes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        line_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        keep,
    output logic [15:0] out_unit,
    output logic        out_line_end
);

    // input register
    logic  in_valid_reg;
    logic  in_valid_next;
    unit_t in_unit_reg;
    logic  in_eol_reg;

    // result register
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  keep_reg;
    unit_t out_unit_reg;
    logic  out_eol_reg;

    logic  in_accept;
    logic  advance;
    logic  keep_now;
    mode_t mode;

    // Advance the input register into the result register whenever the
    // result register is empty or its transaction leaves this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    tes_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .code_unit (in_unit_reg),
        .line_end  (in_eol_reg),
        .keep      (keep_now),
        .mode      (mode)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_unit_reg <= code_unit;
            in_eol_reg  <= line_end;
        end
        if (advance)
        begin
            keep_reg     <= keep_now;
            out_unit_reg <= keep_now ? in_unit_reg : '0;
            out_eol_reg  <= in_eol_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign keep         = keep_reg;
    assign out_unit     = out_unit_reg;
    assign out_line_end = out_eol_reg;

    // Dropped units carry a zero payload.
    `TES_ASSERT_NOW(a_drop_zero, out_valid_reg && !keep_reg, out_unit_reg == '0)
    // Kept units never come from the C1 control range.
    `TES_ASSERT_NOW(a_no_c1, out_valid_reg && keep_reg,
        !(out_unit_reg >= U_C1_LO && out_unit_reg < U_C1_END))
    // A line end leaves the parser in normal text.
    `TES_ASSERT_NEXT(a_eol_normal, advance && in_eol_reg, mode == MODE_NORMAL)
    // Input stalls only while both the input and result registers hold a transaction.
    `TES_ASSERT_NOW(a_stall_full, in_stall, in_valid_reg && out_valid_reg)

endmodule
